### hdl/bwb_pkg.sv
// ----------------------------------------------------------------------------
// bwb_pkg
// Shared types and constants of the binary window bond extractor.
// ----------------------------------------------------------------------------
package bwb_pkg;

    localparam int ROW_BITS = 12;
    localparam int DOT_BITS = 25;
    localparam logic [DOT_BITS-1:0] DOT_MAX = {DOT_BITS{1'b1}};
    localparam logic [12:0] ROW_LIMIT = 13'd4096;

    typedef struct packed {
        logic                frame_end;
        logic [DOT_BITS-1:0] dot_total;
        logic                isolated_dot;
        logic [3:0]          bond_value;
        logic [7:0]          neighbour_byte;
        logic                centre_bit;
        logic [11:0]         column_index;
        logic [ROW_BITS-1:0] row_index;
    } t_result;

endpackage

### hdl/binary_window_bond_extractor.sv
// ----------------------------------------------------------------------------
// binary_window_bond_extractor
// Binarises a raster pixel stream and emits the 3x3 neighbour byte, bond,
// isolated-dot flag and running dot count of every pixel's window.
//
// Channel   Signals                               Contents
// s (in)    i_s_tvalid/o_s_tready/i_s_tdata/tuser tdata: pixel_value; tuser: func
// m (out)   o_m_tvalid/i_m_tready/o_m_tdata/tlast one window; tlast: frame_end
// cfg       i_cfg_we/i_cfg_index/i_cfg_data       0 width, 1 height, 2 fg black
//
// One item per cycle when s_tready is high; r_s1 then the queue hold results.
// Windows are kept in a four-entry queue; s_tready drops while that queue
// lacks room for the results still in flight (a last-column pixel makes two).
// Row stores are one dual-read RAM of {older, newer} bits; no clearing pass.
// Reset (synchronous, active low) clears counters, queue and pipeline valid.
// ----------------------------------------------------------------------------
module binary_window_bond_extractor #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] pixel_value
    input  logic        i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [11:0] row_index, [23:12] column_index, [24] centre_bit,
    // [32:25] neighbour_byte, [36:33] bond_value, [37] isolated_dot,
    // [62:38] dot_total, [63] zero
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast,   // frame_end
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    import bwb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RESET_W = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
    localparam logic [AW-1:0] RESET_LAST_COL = AW'(RESET_W - 1);
    localparam logic [ROW_BITS-1:0] RESET_LAST_ROW = ROW_BITS'(511);
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FG     = 2'd2;

    typedef struct packed {
        logic                pix;
        logic                bin;
        logic [AW-1:0]       col;
        logic [ROW_BITS-1:0] row;
        logic                c_nz;
        logic                c_last;
        logic                row_nz;
        logic                row_ge2;
        logic                h_ge2;
        logic                d_nz;
        logic                d_last;
        logic                byp_a;
        logic [1:0]          byp_a_data;
        logic                byp_b;
        logic [1:0]          byp_b_data;
        logic [1:0]          cnt;
    } t_stage;

    // configuration
    logic [AW-1:0]       r_last_col;
    logic [ROW_BITS-1:0] r_last_row;
    logic                r_fg_black;
    logic [WW-1:0]       cfg_w_used;
    logic [12:0]         cfg_h_used;
    logic [12:0]         cfg_h_m1;
    logic                geom_wr;

    // input side counters
    logic [AW-1:0]       r_in_col,    n_in_col;
    logic [ROW_BITS-1:0] r_in_row,    n_in_row;
    logic                r_rows_done, n_rows_done;
    logic [AW-1:0]       r_drain_col, n_drain_col;

    logic                s_accept, is_pix, pix_ok, drn_ok, bin;
    logic                c_nz, c_last, row_nz, row_ge2, d_nz, d_last;
    logic [1:0]          pix_cnt;
    logic [AW-1:0]       addr_a, addr_b;

    // window stage
    t_stage              r_s1, n_s1;
    logic                r_s1_valid;
    logic [8:0]          r_shift;
    logic [2:0]          r_prev_cc;
    logic [DOT_BITS-1:0] r_dot;

    logic [1:0]          ram_qa, ram_qb, qa, qb, ram_wdata;
    logic                ram_we;
    logic [2:0]          colv, cc_d, rc_d, lc_d;
    logic [8:0]          sh_new;
    logic                e1;
    logic [2:0]          w0_l, w0_c, w0_r, w1_l;
    logic [AW-1:0]       w0_col;
    logic [31:0]         w0_col_wide, w1_col_wide;
    logic                w0_fend;
    logic [DOT_BITS-1:0] dot0, dot1;
    t_result             res0, res1, q_item;
    logic [1:0]          q_push_n;
    logic [2:0]          q_free;
    logic                q_valid;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb begin
        if (i_cfg_data == 13'd0) begin
            cfg_w_used = WW'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            cfg_w_used = WW'(MAX_WIDTH);
        end else begin
            cfg_w_used = WW'(i_cfg_data);
        end
        if (i_cfg_data == 13'd0) begin
            cfg_h_used = 13'd1;
        end else if (i_cfg_data > ROW_LIMIT) begin
            cfg_h_used = ROW_LIMIT;
        end else begin
            cfg_h_used = i_cfg_data;
        end
        cfg_h_m1 = cfg_h_used - 13'd1;
    end

    assign geom_wr = i_cfg_we && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= RESET_LAST_COL;
            r_last_row <= RESET_LAST_ROW;
            r_fg_black <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_last_col <= AW'(cfg_w_used - WW'(1));
                CFG_HEIGHT: r_last_row <= cfg_h_m1[ROW_BITS-1:0];
                CFG_FG:     r_fg_black <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // accept stage
    // ------------------------------------------------------------------
    assign o_s_tready = (q_free >= (3'(q_push_n) + 3'd2));
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign is_pix     = !i_s_tuser;
    assign pix_ok     = s_accept && is_pix && !r_rows_done;
    assign drn_ok     = s_accept && !is_pix && r_rows_done;
    assign bin        = r_fg_black ? (i_s_tdata == 8'd0) : (i_s_tdata != 8'd0);

    assign c_nz    = (r_in_col != '0);
    assign c_last  = (r_in_col == r_last_col);
    assign row_nz  = (r_in_row != '0);
    assign row_ge2 = |r_in_row[ROW_BITS-1:1];
    assign d_nz    = (r_drain_col != '0);
    assign d_last  = (r_drain_col == r_last_col);
    assign pix_cnt = row_nz ? (2'(c_nz) + 2'(c_last)) : 2'd0;
    assign addr_a  = is_pix ? r_in_col : r_drain_col;
    assign addr_b  = r_drain_col + AW'(1);

    always_comb begin
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_rows_done = r_rows_done;
        n_drain_col = r_drain_col;
        if (geom_wr) begin
            n_in_col    = '0;
            n_in_row    = '0;
            n_rows_done = 1'b0;
            n_drain_col = '0;
        end else if (pix_ok) begin
            if (c_last) begin
                n_in_col = '0;
                if (r_in_row == r_last_row) begin
                    n_rows_done = 1'b1;
                end else begin
                    n_in_row = r_in_row + ROW_BITS'(1);
                end
            end else begin
                n_in_col = r_in_col + AW'(1);
            end
        end else if (drn_ok) begin
            if (d_last) begin
                n_in_col    = '0;
                n_in_row    = '0;
                n_rows_done = 1'b0;
                n_drain_col = '0;
            end else begin
                n_drain_col = r_drain_col + AW'(1);
            end
        end
    end

    always_comb begin
        n_s1.pix        = is_pix;
        n_s1.bin        = bin;
        n_s1.col        = addr_a;
        n_s1.row        = is_pix ? (r_in_row - ROW_BITS'(1)) : r_last_row;
        n_s1.c_nz       = c_nz;
        n_s1.c_last     = c_last;
        n_s1.row_nz     = row_nz;
        n_s1.row_ge2    = row_ge2;
        n_s1.h_ge2      = (r_last_row != '0);
        n_s1.d_nz       = d_nz;
        n_s1.d_last     = d_last;
        n_s1.byp_a      = ram_we && (r_s1.col == addr_a);
        n_s1.byp_a_data = ram_wdata;
        n_s1.byp_b      = ram_we && (r_s1.col == addr_b);
        n_s1.byp_b_data = ram_wdata;
        n_s1.cnt        = pix_ok ? pix_cnt : 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_rows_done <= 1'b0;
            r_drain_col <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_rows_done <= n_rows_done;
            r_drain_col <= n_drain_col;
            r_s1_valid  <= pix_ok || drn_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // ------------------------------------------------------------------
    // row store: bit1 older row, bit0 newer row
    // ------------------------------------------------------------------
    bwb_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_s1.col),
        .i_wdata   (ram_wdata),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (ram_qa),
        .o_rdata_b (ram_qb)
    );

    // ------------------------------------------------------------------
    // window stage
    // ------------------------------------------------------------------
    assign qa        = r_s1.byp_a ? r_s1.byp_a_data : ram_qa;
    assign qb        = r_s1.byp_b ? r_s1.byp_b_data : ram_qb;
    assign ram_we    = r_s1_valid && r_s1.pix;
    assign ram_wdata = {qa[0], r_s1.bin};

    assign colv   = {r_s1.bin, r_s1.row_nz & qa[0], r_s1.row_ge2 & qa[1]};
    assign sh_new = r_s1.c_nz ? {r_shift[5:0], colv} : {6'd0, colv};
    assign e1     = r_s1.row_nz && r_s1.c_nz;

    assign cc_d = {1'b0, qa[0], r_s1.h_ge2 & qa[1]};
    assign rc_d = r_s1.d_last ? 3'd0 : {1'b0, qb[0], r_s1.h_ge2 & qb[1]};
    assign lc_d = r_s1.d_nz ? r_prev_cc : 3'd0;
    assign w1_l = r_s1.c_nz ? sh_new[5:3] : 3'd0;

    always_comb begin
        if (!r_s1.pix) begin
            w0_l    = lc_d;
            w0_c    = cc_d;
            w0_r    = rc_d;
            w0_col  = r_s1.col;
            w0_fend = r_s1.d_last;
        end else if (e1) begin
            w0_l    = sh_new[8:6];
            w0_c    = sh_new[5:3];
            w0_r    = sh_new[2:0];
            w0_col  = r_s1.col - AW'(1);
            w0_fend = 1'b0;
        end else begin
            w0_l    = w1_l;
            w0_c    = sh_new[2:0];
            w0_r    = 3'd0;
            w0_col  = r_s1.col;
            w0_fend = 1'b0;
        end
    end

    assign w0_col_wide = 32'(w0_col);
    assign w1_col_wide = 32'(r_s1.col);

    bwb_window u_win0 (
        .i_left      (w0_l),
        .i_centre    (w0_c),
        .i_right     (w0_r),
        .i_row       (r_s1.row),
        .i_col       (w0_col_wide[11:0]),
        .i_frame_end (w0_fend),
        .i_dot       (r_dot),
        .o_result    (res0),
        .o_dot       (dot0)
    );

    bwb_window u_win1 (
        .i_left      (w1_l),
        .i_centre    (sh_new[2:0]),
        .i_right     (3'd0),
        .i_row       (r_s1.row),
        .i_col       (w1_col_wide[11:0]),
        .i_frame_end (1'b0),
        .i_dot       (dot0),
        .o_result    (res1),
        .o_dot       (dot1)
    );

    assign q_push_n = r_s1_valid ? r_s1.cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot     <= '0;
            r_shift   <= '0;
            r_prev_cc <= '0;
        end else if (geom_wr) begin
            r_dot     <= '0;
            r_shift   <= '0;
            r_prev_cc <= '0;
        end else if (r_s1_valid) begin
            if (r_s1.pix) begin
                r_shift <= sh_new;
                case (r_s1.cnt)
                    2'd2:    r_dot <= dot1;
                    2'd1:    r_dot <= dot0;
                    default: r_dot <= r_dot;
                endcase
            end else begin
                r_prev_cc <= cc_d;
                r_dot     <= r_s1.d_last ? '0 : dot0;
            end
        end
    end

    bwb_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (q_push_n),
        .i_item0  (res0),
        .i_item1  (res1),
        .o_valid  (q_valid),
        .i_ready  (i_m_tready),
        .o_item   (q_item),
        .o_free   (q_free)
    );

    assign o_m_tvalid = q_valid;
    assign o_m_tlast  = q_item.frame_end;
    assign o_m_tdata  = {1'b0, q_item.dot_total, q_item.isolated_dot, q_item.bond_value,
                         q_item.neighbour_byte, q_item.centre_bit, q_item.column_index,
                         q_item.row_index};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        3'(q_push_n) <= q_free)
        else $error("result queue overflow");

    a_late_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !i_s_tuser && r_rows_done) |=> !r_s1_valid)
        else $error("pixel after frame end entered window stage");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1.pix && r_s1.d_last) |->
        (r_drain_col == '0 && r_in_col == '0 && !r_rows_done))
        else $error("counters not restarted after last drain");

    a_write_pixel_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> $past(pix_ok))
        else $error("row store written without a pixel transfer");

endmodule

### hdl/bwb_ram.sv
// ----------------------------------------------------------------------------
// bwb_ram
// Generic RAM: one write port, two read ports, registered read (old data on
// a same-address read and write).
// ----------------------------------------------------------------------------
module bwb_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### hdl/bwb_window.sv
// ----------------------------------------------------------------------------
// bwb_window
// Builds one result from three window columns (bit0 up, bit1 middle,
// bit2 down): neighbour byte, bond, isolated-dot flag, saturating dot count.
// ----------------------------------------------------------------------------
module bwb_window (
    input  logic [2:0]                      i_left,
    input  logic [2:0]                      i_centre,
    input  logic [2:0]                      i_right,
    input  logic [bwb_pkg::ROW_BITS-1:0]    i_row,
    input  logic [11:0]                     i_col,
    input  logic                            i_frame_end,
    input  logic [bwb_pkg::DOT_BITS-1:0]    i_dot,
    output bwb_pkg::t_result                o_result,
    output logic [bwb_pkg::DOT_BITS-1:0]    o_dot
);

    import bwb_pkg::*;

    function automatic logic [7:0] pack_neighbours(input logic [2:0] lc,
                                                   input logic [2:0] cc,
                                                   input logic [2:0] rc);
        return {rc[2], cc[2], lc[2], lc[1], lc[0], cc[0], rc[0], rc[1]};
    endfunction

    function automatic logic [3:0] bond_of(input logic [7:0] nb);
        logic [3:0] edges;
        logic [3:0] diags;
        edges = 4'(nb[0]) + 4'(nb[2]) + 4'(nb[4]) + 4'(nb[6]);
        diags = 4'(nb[1]) + 4'(nb[3]) + 4'(nb[5]) + 4'(nb[7]);
        return {edges[2:0], 1'b0} + diags;
    endfunction

    logic [7:0] nb;
    logic       iso;

    assign nb  = pack_neighbours(i_left, i_centre, i_right);
    assign iso = i_centre[1] && (nb == 8'd0);
    assign o_dot = (iso && (i_dot != DOT_MAX)) ? i_dot + DOT_BITS'(1) : i_dot;

    always_comb begin
        o_result.frame_end      = i_frame_end;
        o_result.dot_total      = o_dot;
        o_result.isolated_dot   = iso;
        o_result.bond_value     = bond_of(nb);
        o_result.neighbour_byte = nb;
        o_result.centre_bit     = i_centre[1];
        o_result.column_index   = i_col;
        o_result.row_index      = i_row;
    end

endmodule

### hdl/bwb_out_queue.sv
// ----------------------------------------------------------------------------
// bwb_out_queue
// Four-entry result queue; takes up to two results a cycle, gives one while i_ready.
// ----------------------------------------------------------------------------
module bwb_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  bwb_pkg::t_result i_item0,
    input  bwb_pkg::t_result i_item1,
    output logic             o_valid,
    input  logic             i_ready,
    output bwb_pkg::t_result o_item,
    output logic [2:0]       o_free
);

    import bwb_pkg::*;

    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);

    t_result          r_mem [QD];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;
    logic [QAW-1:0]   wr_next;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_free  = 3'(QD) - 3'(r_count);
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr_ptr + QAW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_item0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_next] <= i_item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QAW'(i_push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + (QAW+1)'(i_push_n) - (QAW+1)'(pop);
        end
    end

endmodule
